FILE: src/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// Shared constants, request codes and control types of the Jacobi stencil
// engine.
// ----------------------------------------------------------------------------
package jse_pkg;

   // field widths
   localparam int CELL_W     = 16;  // signed Q1.14 cell
   localparam int COORD_W    = 6;   // row / column field
   localparam int REQ_TYPE_W = 2;
   localparam int GRID_W     = 6;   // grid_size register
   localparam int ITER_W     = 16;  // iteration_count register
   localparam int SUM_W      = CELL_W + 2;  // sum of four cells

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_SIZE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ITER      = 1'd1;

   localparam logic [GRID_W-1:0] GRID_SIZE_RESET = 6'd8;
   localparam logic [ITER_W-1:0] ITER_RESET      = 16'd1;

   localparam int PADDED_SIDE_DEFAULT = 64;

   // request codes
   typedef logic [REQ_TYPE_W-1:0] req_code_type;
   localparam req_code_type REQ_LOAD = 2'd0;
   localparam req_code_type REQ_RUN  = 2'd1;
   localparam req_code_type REQ_READ = 2'd2;

   // status from the sweep sequencer to the top level
   typedef struct packed {
      logic busy;        // a run is in progress
      logic rd_en;       // source buffer read this cycle
      logic wr_en;       // destination buffer write this cycle
      logic sweep_done;  // last cycle of a sweep: swap buffers
   } sweep_stat_type;

endpackage

FILE: src/jse_if.sv
// ----------------------------------------------------------------------------
// jse_req_if / jse_rsp_if
// Valid/ready channels of the Jacobi stencil engine: request words in,
// read-back words out.
// ----------------------------------------------------------------------------
interface jse_req_if;
   import jse_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [REQ_TYPE_W-1:0]     req_type;
   logic [COORD_W-1:0]        row;
   logic [COORD_W-1:0]        col;
   logic signed [CELL_W-1:0]  cell_value;

   modport source (output valid, req_type, row, col, cell_value, input ready);
   modport sink   (input valid, req_type, row, col, cell_value, output ready);
endinterface

interface jse_rsp_if;
   import jse_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [CELL_W-1:0]  read_value;
   logic [COORD_W-1:0]        read_row;
   logic [COORD_W-1:0]        read_col;

   modport source (output valid, read_value, read_row, read_col, input ready);
   modport sink   (input valid, read_value, read_row, read_col, output ready);
endinterface

FILE: src/jse_buf.sv
// ----------------------------------------------------------------------------
// jse_buf
// One grid buffer: synchronous memory with one write port and one read port,
// read data registered.
// ----------------------------------------------------------------------------
module jse_buf #(
   parameter int AW = 12
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [AW-1:0]                    waddr,
   input  logic [jse_pkg::CELL_W-1:0]       wdata,
   input  logic                             re,
   input  logic [AW-1:0]                    raddr,
   output logic [jse_pkg::CELL_W-1:0]       rdata
);
   import jse_pkg::*;

   localparam int DEPTH = 1 << AW;

   logic [CELL_W-1:0] mem_ff [DEPTH];
   logic [CELL_W-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/jse_sweep.sv
// ----------------------------------------------------------------------------
// jse_sweep
// Sweep sequencer: walks the interior cells, reads the four neighbors of each
// from the source buffer, accumulates them and writes the floored quarter to
// the destination buffer. Repeats for the requested number of sweeps.
// ----------------------------------------------------------------------------
module jse_sweep #(
   parameter int PADDED_SIDE = jse_pkg::PADDED_SIDE_DEFAULT,
   localparam int CW = $clog2(PADDED_SIDE),
   localparam int AW = 2 * CW
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [jse_pkg::GRID_W-1:0]          grid_size,
   input  logic [jse_pkg::ITER_W-1:0]          iter_count,
   input  logic signed [jse_pkg::CELL_W-1:0]   src_rdata,
   output jse_pkg::sweep_stat_type             stat,
   output logic [AW-1:0]                       rd_addr,
   output logic [AW-1:0]                       wr_addr,
   output logic [jse_pkg::CELL_W-1:0]          wr_data
);
   import jse_pkg::*;

   localparam int MAX_N = PADDED_SIDE - 2;
   localparam int NW    = (CW > GRID_W) ? CW : GRID_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   // neighbor order within one cell
   localparam logic [1:0] PH_N = 2'd0;
   localparam logic [1:0] PH_S = 2'd1;
   localparam logic [1:0] PH_W = 2'd2;
   localparam logic [1:0] PH_E = 2'd3;

   logic [1:0]              state_ff, state_in;
   logic [CW-1:0]           row_ff, row_in;
   logic [CW-1:0]           col_ff, col_in;
   logic [1:0]              ph_ff, ph_in;
   logic [ITER_W-1:0]       left_ff, left_in;
   logic                    d_valid_ff;
   logic [1:0]              d_ph_ff;
   logic [CW-1:0]           d_row_ff;
   logic [CW-1:0]           d_col_ff;
   logic signed [SUM_W-1:0] acc_ff;
   logic signed [SUM_W-1:0] sum_in;

   logic [NW-1:0]           gs_w;
   logic [CW-1:0]           n_eff;
   logic                    n_zero;
   logic                    issue;
   logic                    last_cell;

   // interior size clamped to the padded grid
   assign gs_w   = NW'(grid_size);
   assign n_eff  = (gs_w > NW'(MAX_N)) ? CW'(MAX_N) : CW'(gs_w);
   assign n_zero = (n_eff == '0);

   assign issue     = (state_ff == ST_RUN) && !n_zero;
   assign last_cell = (row_ff == n_eff) && (col_ff == n_eff) && (ph_ff == PH_E);

   // neighbor address
   always_comb begin
      unique case (ph_ff)
         PH_N: rd_addr = {row_ff - CW'(1), col_ff};
         PH_S: rd_addr = {row_ff + CW'(1), col_ff};
         PH_W: rd_addr = {row_ff, col_ff - CW'(1)};
         PH_E: rd_addr = {row_ff, col_ff + CW'(1)};
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      ph_in    = ph_ff;
      left_in  = left_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               left_in  = (iter_count == '0) ? ITER_W'(1) : iter_count;
               row_in   = CW'(1);
               col_in   = CW'(1);
               ph_in    = PH_N;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (n_zero || last_cell) begin
               state_in = ST_DRAIN;
            end else begin
               ph_in = ph_ff + 2'd1;
               if (ph_ff == PH_E) begin
                  if (col_ff == n_eff) begin
                     col_in = CW'(1);
                     row_in = row_ff + CW'(1);
                  end else begin
                     col_in = col_ff + CW'(1);
                  end
               end
            end
         end
         ST_DRAIN: begin
            // last write lands this cycle; next sweep reads after it
            if (left_ff == ITER_W'(1)) begin
               state_in = ST_IDLE;
            end else begin
               left_in  = left_ff - ITER_W'(1);
               row_in   = CW'(1);
               col_in   = CW'(1);
               ph_in    = PH_N;
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         d_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         d_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      row_ff   <= row_in;
      col_ff   <= col_in;
      ph_ff    <= ph_in;
      left_ff  <= left_in;
      d_ph_ff  <= ph_ff;
      d_row_ff <= row_ff;
      d_col_ff <= col_ff;
      if (d_valid_ff) begin
         acc_ff <= sum_in;
      end
   end

   // neighbor accumulation; the first neighbor restarts the sum
   assign sum_in = (d_ph_ff == PH_N) ? SUM_W'(src_rdata) : acc_ff + SUM_W'(src_rdata);

   // floor of a quarter: drop the two low bits of the signed sum
   assign wr_data = sum_in[SUM_W-1:2];
   assign wr_addr = {d_row_ff, d_col_ff};

   assign stat.busy       = (state_ff != ST_IDLE);
   assign stat.rd_en      = issue;
   assign stat.wr_en      = d_valid_ff && (d_ph_ff == PH_E);
   assign stat.sweep_done = (state_ff == ST_DRAIN);

   // no read is left in flight once a sweep has drained
   a_drain_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |=> !d_valid_ff)
      else $error("read still in flight after sweep drain");

   // sweep counter never underflows
   a_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      stat.sweep_done |-> (left_ff != '0))
      else $error("sweep count exhausted while sweeping");

   // cell walk stays inside the interior
   a_cell_range: assert property (@(posedge clock) disable iff (reset)
      issue |-> (row_ff != '0) && (row_ff <= n_eff) && (col_ff != '0) && (col_ff <= n_eff))
      else $error("sweep cell outside interior");

   // every fourth returned neighbor produces a write of that cell
   a_write_cell: assert property (@(posedge clock) disable iff (reset)
      (issue && (ph_ff == PH_E)) |=> stat.wr_en && (wr_addr == $past({row_ff, col_ff})))
      else $error("cell write missing after east neighbor");

endmodule

FILE: src/jacobi_stencil_engine_unit.sv
// ----------------------------------------------------------------------------
// jacobi_stencil_engine_unit
// Jacobi relaxation engine over a padded square grid of Q1.14 cells held in
// two ping-pong buffers.
//
//   channel  dir  handshake        words
//   req_     in   valid / ready    load cell, run sweeps, read cell
//   rsp_     out  valid / ready    one word per read request
//   csr_     in   write enable     grid_size, iteration_count
//
// A run sweeps the interior of n by n cells, n the clamped grid size: the
// single read port of the source buffer delivers one neighbor per cycle.
// No words are taken while a run is in progress.
// Reset clears the control state only; grid buffers need no clearing pass.
// A read result waits in an output register; a second read waits in the
// buffer read register; further words stall until the output is taken.
// ----------------------------------------------------------------------------
module jacobi_stencil_engine_unit #(
   parameter int PADDED_SIDE = jse_pkg::PADDED_SIDE_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   jse_req_if.sink                            req_chan,
   jse_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [jse_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [jse_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import jse_pkg::*;

   localparam int CW = $clog2(PADDED_SIDE);
   localparam int AW = 2 * CW;
   localparam int IW = (CW > COORD_W) ? CW : COORD_W;

   logic [GRID_W-1:0]        grid_size_ff;
   logic [ITER_W-1:0]        iter_ff;
   logic                     cur_odd_ff;
   logic                     pend_valid_ff, pend_valid_in;
   logic                     pend_odd_ff;
   logic                     pend_inrange_ff;
   logic [COORD_W-1:0]       pend_row_ff;
   logic [COORD_W-1:0]       pend_col_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [CELL_W-1:0] rsp_value_ff;
   logic [COORD_W-1:0]       rsp_row_ff;
   logic [COORD_W-1:0]       rsp_col_ff;

   sweep_stat_type           stat;
   logic [AW-1:0]            sw_rd_addr;
   logic [AW-1:0]            sw_wr_addr;
   logic [CELL_W-1:0]        sw_wr_data;

   logic                     req_accept;
   logic                     run_start;
   logic                     load_we;
   logic                     rd_accept;
   logic                     rd_mem;
   logic [IW-1:0]            row_w;
   logic [IW-1:0]            col_w;
   logic                     in_range;
   logic [AW-1:0]            req_addr;
   logic                     rsp_load;

   logic                     even_we, odd_we, even_re, odd_re;
   logic [AW-1:0]            waddr, raddr;
   logic [CELL_W-1:0]        wdata;
   logic [CELL_W-1:0]        even_rdata, odd_rdata;
   logic [CELL_W-1:0]        src_rdata, pend_rdata;

   // request decode
   assign req_chan.ready = !stat.busy && !(pend_valid_ff && rsp_valid_ff);
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign row_w    = IW'(req_chan.row);
   assign col_w    = IW'(req_chan.col);
   assign in_range = ({1'b0, row_w} < (IW + 1)'(PADDED_SIDE))
                  && ({1'b0, col_w} < (IW + 1)'(PADDED_SIDE));
   assign req_addr = {row_w[CW-1:0], col_w[CW-1:0]};

   assign run_start = req_accept && (req_chan.req_type == REQ_RUN);
   assign load_we   = req_accept && (req_chan.req_type == REQ_LOAD) && in_range;
   assign rd_accept = req_accept && (req_chan.req_type == REQ_READ);
   assign rd_mem    = rd_accept && in_range;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= GRID_SIZE_RESET;
         iter_ff      <= ITER_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_SIZE: grid_size_ff <= csr_wdata[GRID_W-1:0];
            CSR_ITER:      iter_ff      <= csr_wdata[ITER_W-1:0];
         endcase
      end
   end

   // buffer ports: loads write both, sweeps write the one not current
   assign even_we = load_we || (stat.wr_en && cur_odd_ff);
   assign odd_we  = load_we || (stat.wr_en && !cur_odd_ff);
   assign even_re = (stat.rd_en || rd_mem) && !cur_odd_ff;
   assign odd_re  = (stat.rd_en || rd_mem) && cur_odd_ff;
   assign waddr   = stat.busy ? sw_wr_addr : req_addr;
   assign wdata   = stat.busy ? sw_wr_data : req_chan.cell_value;
   assign raddr   = stat.busy ? sw_rd_addr : req_addr;

   jse_buf #(.AW(AW)) u_even (
      .clock (clock),
      .we    (even_we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (even_re),
      .raddr (raddr),
      .rdata (even_rdata)
   );

   jse_buf #(.AW(AW)) u_odd (
      .clock (clock),
      .we    (odd_we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (odd_re),
      .raddr (raddr),
      .rdata (odd_rdata)
   );

   assign src_rdata = cur_odd_ff ? odd_rdata : even_rdata;

   jse_sweep #(.PADDED_SIDE(PADDED_SIDE)) u_sweep (
      .clock      (clock),
      .reset      (reset),
      .start      (run_start),
      .grid_size  (grid_size_ff),
      .iter_count (iter_ff),
      .src_rdata  (src_rdata),
      .stat       (stat),
      .rd_addr    (sw_rd_addr),
      .wr_addr    (sw_wr_addr),
      .wr_data    (sw_wr_data)
   );

   // buffer swap after every sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_odd_ff <= 1'b0;
      end else if (stat.sweep_done) begin
         cur_odd_ff <= !cur_odd_ff;
      end
   end

   // read pending in the buffer read register, then the output register
   assign pend_rdata   = pend_odd_ff ? odd_rdata : even_rdata;
   assign rsp_load     = pend_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign pend_valid_in = rd_accept || (pend_valid_ff && !rsp_load);
   assign rsp_valid_in  = rsp_load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_accept) begin
         pend_odd_ff     <= cur_odd_ff;
         pend_inrange_ff <= in_range;
         pend_row_ff     <= req_chan.row;
         pend_col_ff     <= req_chan.col;
      end
      if (rsp_load) begin
         rsp_value_ff <= pend_inrange_ff ? pend_rdata : '0;
         rsp_row_ff   <= pend_row_ff;
         rsp_col_ff   <= pend_col_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.read_row   = rsp_row_ff;
   assign rsp_chan.read_col   = rsp_col_ff;

   // a waiting read is kept while the output stalls
   a_pend_kept: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && rsp_valid_ff && !rsp_chan.ready) |=> pend_valid_ff)
      else $error("pending read lost while output stalled");

   // sweep writes never collide with a load write
   a_no_wr_clash: assert property (@(posedge clock) disable iff (reset)
      stat.wr_en |-> !load_we)
      else $error("sweep write collides with load");

   // every read request reaches the pending stage
   a_read_pend: assert property (@(posedge clock) disable iff (reset)
      rd_accept |=> pend_valid_ff)
      else $error("read request not held for output");

   // a run starts the sequencer on the next cycle
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      run_start |=> stat.busy)
      else $error("run request did not start sweeping");

endmodule

FILE: tb/sv/jse_readback_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jse_readback_checker
// Passive checker for the Jacobi stencil engine. It watches the request,
// read-back and register ports. It keeps its own copy of both grid buffers,
// of the buffer select and of the registers. Every read-back word is compared
// field by field against the oldest predicted cell read.
// ----------------------------------------------------------------------------
module jse_readback_checker
   import jse_pkg::*;
#(
   parameter int PADDED_SIDE = PADDED_SIDE_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   jse_req_if                    req_mon,
   jse_rsp_if                    rsp_mon,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatches,
   output int                    reads_due
);
   localparam int CELLS = PADDED_SIDE * PADDED_SIDE;

   typedef struct packed {
      logic [CELL_W-1:0]  value;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } cell_read_type;

   // ping-pong buffers: index 0 even, index 1 odd
   logic [CELL_W-1:0] grid [2][CELLS];
   bit                odd_latest;
   logic [GRID_W-1:0] grid_size;
   logic [ITER_W-1:0] sweep_count;
   cell_read_type     reads_pending [$];

   initial begin
      mismatches = 0;
      foreach (grid[b, i]) grid[b][i] = '0;
   end

   task automatic report_mismatch(input string what);
      if (mismatches < 100) $display("%0t chk: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      int                      n;
      int                      passes;
      int                      at;
      bit                      src;
      bit                      in_range;
      logic signed [SUM_W-1:0] quarter;
      cell_read_type           want;

      if (reset) begin
         reads_pending.delete();
         odd_latest  = 1'b0;
         grid_size   = GRID_SIZE_RESET;
         sweep_count = ITER_RESET;
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               CSR_GRID_SIZE: grid_size = csr_wdata[GRID_W-1:0];
               CSR_ITER:      sweep_count = csr_wdata[ITER_W-1:0];
               default: ;
            endcase
         end

         // read-back word vs. oldest pending read
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (reads_pending.size() == 0) begin
               report_mismatch($sformatf("read-back word (%0d,%0d) with no read pending",
                                         rsp_mon.read_row, rsp_mon.read_col));
            end else begin
               want = reads_pending.pop_front();
               if (rsp_mon.read_value !== want.value)
                  report_mismatch($sformatf("cell (%0d,%0d): value %h, predicted %h",
                                            want.row, want.col, rsp_mon.read_value,
                                            want.value));
               if (rsp_mon.read_row !== want.row)
                  report_mismatch($sformatf("read_row %0d, predicted %0d",
                                            rsp_mon.read_row, want.row));
               if (rsp_mon.read_col !== want.col)
                  report_mismatch($sformatf("read_col %0d, predicted %0d",
                                            rsp_mon.read_col, want.col));
            end
         end

         // request word
         if (req_mon.valid && req_mon.ready) begin
            in_range = int'(req_mon.row) < PADDED_SIDE && int'(req_mon.col) < PADDED_SIDE;
            at       = int'(req_mon.row) * PADDED_SIDE + int'(req_mon.col);
            case (req_mon.req_type)
               REQ_LOAD: begin
                  // a load lands in both buffers
                  if (in_range) begin
                     grid[0][at] = req_mon.cell_value;
                     grid[1][at] = req_mon.cell_value;
                  end
               end
               REQ_RUN: begin
                  // interior clamps to the padded side; a zero count still sweeps once
                  n = int'(grid_size);
                  if (n > PADDED_SIDE - 2) n = PADDED_SIDE - 2;
                  passes = (sweep_count == '0) ? 1 : int'(sweep_count);
                  repeat (passes) begin
                     src = odd_latest;
                     for (int r = 1; r <= n; r++) begin
                        for (int c = 1; c <= n; c++) begin
                           at = r * PADDED_SIDE + c;
                           // 18-bit sum, floored quarter
                           quarter = (SUM_W'($signed(grid[src][at - PADDED_SIDE]))
                                    + SUM_W'($signed(grid[src][at + PADDED_SIDE]))
                                    + SUM_W'($signed(grid[src][at - 1]))
                                    + SUM_W'($signed(grid[src][at + 1]))) >>> 2;
                           grid[!src][at] = quarter[CELL_W-1:0];
                        end
                     end
                     odd_latest = !src;
                  end
               end
               REQ_READ: begin
                  want.row   = req_mon.row;
                  want.col   = req_mon.col;
                  want.value = in_range ? grid[odd_latest][at] : '0;
                  reads_pending.push_back(want);
               end
               default: ;  // undefined code: no effect, no word back
            endcase
         end
      end
      reads_due <= reads_pending.size();
   end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Top of the Jacobi stencil engine testbench. It makes clock and reset,
// preloads the whole padded grid, and drives directed stencil cases and
// register corners. Random phases of load, run and read words follow, with
// random gaps on both channels and one long read-back hold-off. Prediction
// and checking sit in jse_readback_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
   import jse_pkg::*;

   localparam int SIDE          = PADDED_SIDE_DEFAULT;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_WORDS   = 60;
   localparam int HOLD_CYCLES   = 200;
   localparam int HOLD_READS    = 10;
   localparam int DRAIN_CYCLES  = 20;
   localparam int STALL_LIMIT   = 600000;

   localparam req_code_type      REQ_UNDEFINED  = 2'd3;
   localparam logic [CELL_W-1:0] CELL_MAX       = 16'h7FFF;
   localparam logic [CELL_W-1:0] CELL_MIN       = 16'h8000;
   localparam logic [CELL_W-1:0] CELL_MINUS_ONE = 16'hFFFF;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    mismatches;
   int                    reads_due;
   int                    quiet_cycles = 0;
   int                    send_gap_odds;  // percent chance of a gap after a word
   int                    recv_gap_odds;  // percent chance per cycle of a ready gap
   bit                    hold_rsp;
   int                    region_hi;      // last row/col a sweep touches

   jse_req_if req_bus ();
   jse_rsp_if rsp_bus ();

   jacobi_stencil_engine_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   jse_readback_checker #(.PADDED_SIDE(SIDE)) chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .reads_due  (reads_due)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // watchdog: cycles with no word moved and no register write
   always @(posedge clock) begin
      if (reset || csr_we || (req_bus.valid && req_bus.ready)
          || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // read-back ready: random gaps, one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (recv_gap_odds != 0 && $urandom_range(1, 100) <= recv_gap_odds) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // mostly inside the swept region, now and then anywhere
   function automatic logic [COORD_W-1:0] coord_pick();
      if ($urandom_range(0, 7) == 0) return COORD_W'($urandom_range(0, SIDE - 1));
      return COORD_W'($urandom_range(0, region_hi));
   endfunction

   function automatic logic [CELL_W-1:0] cell_pick();
      case ($urandom_range(0, 7))
         0:       return CELL_MAX;
         1:       return CELL_MIN;
         default: return CELL_W'($urandom);
      endcase
   endfunction

   task automatic send_word(input req_code_type kind, input logic [COORD_W-1:0] r,
                            input logic [COORD_W-1:0] c, input logic [CELL_W-1:0] v);
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= kind;
      req_bus.row        <= r;
      req_bus.col        <= c;
      req_bus.cell_value <= v;
      do @(posedge clock); while (!req_bus.ready);
      if (send_gap_odds != 0 && $urandom_range(1, 100) <= send_gap_odds) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (reads_due != 0);
   endtask

   // a read is only taken after any run is over, so its return marks idle
   task automatic settle();
      send_word(REQ_READ, coord_pick(), coord_pick(), cell_pick());
      req_bus.valid <= 1'b0;
      wait_drained();
      repeat (4) @(posedge clock);
   endtask

   // grid_size gets random upper bits, the register keeps the low six
   task automatic set_config(input int size, input int sweeps);
      logic [CSR_DATA_W-1:0] data;
      data              = CSR_DATA_W'($urandom);
      data[GRID_W-1:0]  = GRID_W'(size);
      csr_we    <= 1'b1;
      csr_index <= CSR_GRID_SIZE;
      csr_wdata <= data;
      @(posedge clock);
      csr_index <= CSR_ITER;
      csr_wdata <= CSR_DATA_W'(sweeps);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      region_hi = ((size > SIDE - 2) ? SIDE - 2 : size) + 1;
   endtask

   // loads, runs and reads at random; undefined codes do not count
   task automatic random_words(input int count);
      int sent;
      int pick;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 38) begin
            send_word(REQ_LOAD, coord_pick(), coord_pick(), cell_pick());
            sent++;
         end else if (pick < 50) begin
            send_word(REQ_RUN, coord_pick(), coord_pick(), cell_pick());
            sent++;
         end else if (pick < 95) begin
            send_word(REQ_READ, coord_pick(), coord_pick(), cell_pick());
            sent++;
         end else begin
            send_word(REQ_UNDEFINED, coord_pick(), coord_pick(), cell_pick());
         end
      end
   endtask

   initial begin : stimulus
      int size;
      int sweeps;

      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_GRID_SIZE;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.req_type   = REQ_LOAD;
      req_bus.row        = '0;
      req_bus.col        = '0;
      req_bus.cell_value = '0;
      send_gap_odds      = 10;
      recv_gap_odds      = 10;
      hold_rsp           = 1'b0;
      region_hi          = int'(GRID_SIZE_RESET) + 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // every cell of both buffers is written before anything reads it
      for (int r = 0; r < SIDE; r++)
         for (int c = 0; c < SIDE; c++)
            send_word(REQ_LOAD, COORD_W'(r), COORD_W'(c), cell_pick());

      // padded corners under the reset registers
      send_word(REQ_READ, '0, '0, '0);
      send_word(REQ_READ, '1, '1, '0);

      // (1,1): four max neighbors
      send_word(REQ_LOAD, 6'd0, 6'd1, CELL_MAX);
      send_word(REQ_LOAD, 6'd2, 6'd1, CELL_MAX);
      send_word(REQ_LOAD, 6'd1, 6'd0, CELL_MAX);
      send_word(REQ_LOAD, 6'd1, 6'd2, CELL_MAX);
      // (5,5): four min neighbors
      send_word(REQ_LOAD, 6'd4, 6'd5, CELL_MIN);
      send_word(REQ_LOAD, 6'd6, 6'd5, CELL_MIN);
      send_word(REQ_LOAD, 6'd5, 6'd4, CELL_MIN);
      send_word(REQ_LOAD, 6'd5, 6'd6, CELL_MIN);
      // (7,7): a lone -1 floors to -1
      send_word(REQ_LOAD, 6'd6, 6'd7, CELL_MINUS_ONE);
      send_word(REQ_LOAD, 6'd8, 6'd7, '0);
      send_word(REQ_LOAD, 6'd7, 6'd6, '0);
      send_word(REQ_LOAD, 6'd7, 6'd8, '0);
      send_word(REQ_UNDEFINED, '1, '1, '1);
      send_word(REQ_RUN, '1, '1, '1);
      send_word(REQ_READ, 6'd1, 6'd1, '0);
      send_word(REQ_READ, 6'd5, 6'd5, '0);
      send_word(REQ_READ, 6'd7, 6'd7, '0);
      send_word(REQ_READ, 6'd9, 6'd9, '0);
      send_word(REQ_READ, 6'd0, '1, '0);

      // empty interior: only the buffer select flips, three times
      settle();
      set_config(0, 3);
      send_word(REQ_RUN, '0, '0, '0);
      send_word(REQ_READ, 6'd1, 6'd1, '0);

      // zero count acts as a single sweep
      settle();
      set_config(5, 0);
      send_word(REQ_RUN, '0, '0, '0);
      send_word(REQ_READ, 6'd3, 6'd3, '0);

      // oversize grid clamps to the full padded interior
      settle();
      set_config(63, 1);
      send_word(REQ_RUN, '0, '0, '0);
      send_word(REQ_READ, 6'd62, 6'd62, '0);
      send_word(REQ_READ, 6'd1, 6'd62, '0);

      settle();
      set_config(62, 1);
      send_word(REQ_RUN, '0, '0, '0);
      send_word(REQ_READ, 6'd31, 6'd31, '0);

      // longest count, on an empty interior to keep it short
      settle();
      set_config(0, 65535);
      send_word(REQ_RUN, '0, '0, '0);
      send_word(REQ_READ, 6'd2, 6'd2, '0);

      // random phases, each with its own registers and gap rates
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         size   = $urandom_range(1, 10);
         sweeps = $urandom_range(1, 4);
         case ($urandom_range(0, 5))
            0:       size = 0;
            1:       sweeps = 0;
            default: ;
         endcase
         set_config(size, sweeps);
         send_gap_odds = 15 * $urandom_range(0, 2);
         recv_gap_odds = 15 * $urandom_range(0, 2);
         if (p == 2) begin
            // reads keep coming while read-back is held off: engine fills and stalls
            hold_rsp = 1'b1;
            repeat (HOLD_READS) send_word(REQ_READ, coord_pick(), coord_pick(), cell_pick());
            while (hold_rsp) @(posedge clock);
            // sender pauses until every read-back is home
            req_bus.valid <= 1'b0;
            wait_drained();
         end
         random_words(PHASE_WORDS);
      end

      // last stretch runs without gaps on either side
      settle();
      set_config($urandom_range(1, 8), $urandom_range(1, 3));
      send_gap_odds = 0;
      recv_gap_odds = 0;
      random_words(PHASE_WORDS);

      req_bus.valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && reads_due == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
